// ----- sv/asc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_pkg
// Types, constants and the round function shared by the Ascon blocks.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam logic [63:0] ASC_IV  = 64'h0000_0800_108C_0001;
  localparam logic [63:0] ASC_ALL = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [7:0]  ASC_PAD = 8'h80;
  localparam logic [3:0]  ROUNDS_A = 4'd12;
  localparam logic [3:0]  ROUNDS_B = 4'd8;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_AD    = 2'd1;
  localparam logic [1:0] FUNC_MSG   = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_AD   = 2'd1;
  localparam logic [1:0] PH_ADDONE = 2'd2;
  localparam logic [1:0] PH_MSG  = 2'd3;

  typedef enum logic [1:0] {
    OP_START,
    OP_AD,
    OP_MSG
  } op_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t         op;
    logic [63:0] data;
    logic [3:0]  count;
    logic        fin;
    logic        first_msg;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_INIT_KEY,
    S_ADPERM,
    S_ADPAD,
    S_ADPERM2,
    S_MSGPERM,
    S_MSGPAD,
    S_FIN,
    S_FINPERM,
    S_OUT
  } bstate_t;

  typedef logic [4:0][63:0] st_t;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int s);
    rotr = (v >> s) | (v << (64 - s));
  endfunction

  function automatic logic [63:0] low_mask(input logic [3:0] n);
    low_mask = (n >= 4'd8) ? ASC_ALL : ((64'd1 << {n[2:0], 3'b000}) - 64'd1);
  endfunction

  function automatic logic [63:0] pad_word(input logic [3:0] n);
    pad_word = {56'd0, ASC_PAD} << {n[2:0], 3'b000};
  endfunction

  function automatic st_t round_fn(input st_t si, input logic [3:0] r);
    st_t s;
    st_t t;
    s = si;
    s[2] = s[2] ^ {56'd0, 8'hf0 - {r, 4'h0} + {4'h0, r}};
    s[0] = s[0] ^ s[4];
    s[4] = s[4] ^ s[3];
    s[2] = s[2] ^ s[1];
    for (int i = 0; i < 5; i++) t[i] = ~s[i] & s[(i + 1) % 5];
    for (int i = 0; i < 5; i++) s[i] = s[i] ^ t[(i + 1) % 5];
    s[1] = s[1] ^ s[0];
    s[0] = s[0] ^ s[4];
    s[3] = s[3] ^ s[2];
    s[2] = ~s[2];
    s[0] = s[0] ^ rotr(s[0], 19) ^ rotr(s[0], 28);
    s[1] = s[1] ^ rotr(s[1], 61) ^ rotr(s[1], 39);
    s[2] = s[2] ^ rotr(s[2], 1) ^ rotr(s[2], 6);
    s[3] = s[3] ^ rotr(s[3], 10) ^ rotr(s[3], 17);
    s[4] = s[4] ^ rotr(s[4], 7) ^ rotr(s[4], 41);
    round_fn = s;
  endfunction

endpackage

// ----- sv/asc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_front
// Accepts items, tracks the phase and drops items out of place.
// ----------------------------------------------------------------------------
module asc_front import asc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [63:0] data_in,
  input  logic [3:0]  byte_count,
  input  logic        is_last,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_full
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [3:0] n_sat;
  logic       keep;

  assign full = cmd_full;
  assign n_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;

  always_comb begin
    phase_next = phase;
    keep = 1'b0;
    cmd.op = OP_START;
    cmd.data = data_in;
    cmd.count = is_last ? n_sat : 4'd8;
    cmd.fin = is_last;
    cmd.first_msg = (phase != PH_MSG);
    case (func)
      FUNC_START: begin
        keep = 1'b1;
        phase_next = PH_AD;
      end
      FUNC_AD: begin
        cmd.op = OP_AD;
        if (phase == PH_AD) begin
          keep = 1'b1;
          if (is_last) phase_next = PH_ADDONE;
        end
      end
      FUNC_MSG: begin
        cmd.op = OP_MSG;
        if (phase != PH_IDLE) begin
          keep = 1'b1;
          phase_next = is_last ? PH_IDLE : PH_MSG;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign cmd_valid = push && !full && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (push && !full) begin
      phase <= phase_next;
    end
  end

endmodule

// ----- sv/asc_cmdq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_cmdq
// Two-entry command queue between the front and the permutation core.
// ----------------------------------------------------------------------------
module asc_cmdq import asc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wdata,
  output logic full,
  input  logic rd,
  output cmd_t rdata,
  output logic empty
);

  cmd_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd && !empty) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd && !empty};
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !wr)
    else $error("cmd queue overrun");
  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("cmd queue count out of range");

endmodule

// ----- sv/asc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_core
// Permutation core: one round a cycle, absorb, encrypt/decrypt, finalize.
// ----------------------------------------------------------------------------
module asc_core import asc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_empty,
  input  cmd_t        cmd,
  output logic        cmd_rd,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic [63:0] nonce_low,
  input  logic [63:0] nonce_high,
  input  logic        decrypt_mode,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] data_out,
  output logic [3:0]  out_count,
  output logic [63:0] tag_low,
  output logic [63:0] tag_high,
  output logic        last
);

  bstate_t     st;
  bstate_t     st_next;
  st_t         s;
  st_t         s_next;
  logic [3:0]  rnd;
  logic [3:0]  rnd_next;
  logic        pend;
  logic [63:0] o_next;
  logic        take;
  logic        load_out;
  logic        rnd_done;
  st_t         s_msg;
  logic [63:0] mmask;
  logic [63:0] mpad;

  assign rnd_done = (rnd == 4'd11);
  assign take = (st == S_IDLE) && !cmd_empty && !(cmd.op == OP_MSG && !empty);
  assign cmd_rd = take;

  // message block on word 0
  always_comb begin
    s_msg = s;
    if (cmd.first_msg) s_msg[4] = s[4] ^ 64'd1;
    mmask = (cmd.fin && cmd.count != 4'd8) ? low_mask(cmd.count) : ASC_ALL;
    mpad  = (cmd.fin && cmd.count != 4'd8) ? pad_word(cmd.count) : 64'd0;
    if (decrypt_mode) begin
      o_next = (s[0] ^ cmd.data) & mmask;
      s_msg[0] = (s[0] & ~mmask) ^ (cmd.data & mmask) ^ mpad;
    end else begin
      s_msg[0] = s[0] ^ (cmd.data & mmask) ^ mpad;
      o_next = s_msg[0] & mmask;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_START: st_next = S_INIT;
            OP_AD: st_next = S_ADPERM;
            OP_MSG: begin
              if (!cmd.fin) st_next = S_MSGPERM;
              else if (cmd.count == 4'd8) st_next = S_MSGPAD;
              else st_next = S_FIN;
            end
            default: st_next = S_IDLE;
          endcase
        end
      end
      S_INIT:    if (rnd_done) st_next = S_INIT_KEY;
      S_INIT_KEY: st_next = S_IDLE;
      S_ADPERM:  if (rnd_done) st_next = pend ? S_ADPAD : S_IDLE;
      S_ADPAD:   st_next = S_ADPERM2;
      S_ADPERM2: if (rnd_done) st_next = S_IDLE;
      S_MSGPERM: if (rnd_done) st_next = pend ? S_FIN : S_IDLE;
      S_MSGPAD:  st_next = S_MSGPERM;
      S_FIN:     st_next = S_FINPERM;
      S_FINPERM: if (rnd_done) st_next = S_OUT;
      S_OUT:     st_next = S_IDLE;
      default:   st_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_next = s;
    rnd_next = rnd;
    load_out = 1'b0;
    case (st)
      S_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_START: begin
              s_next = {nonce_high, nonce_low, key_high, key_low, ASC_IV};
              rnd_next = 4'd0;
            end
            OP_AD: begin
              rnd_next = 4'd4;
              if (cmd.fin && cmd.count != 4'd8)
                s_next[0] = s[0] ^ (cmd.data & low_mask(cmd.count)) ^ pad_word(cmd.count);
              else
                s_next[0] = s[0] ^ cmd.data;
            end
            OP_MSG: begin
              s_next = s_msg;
              load_out = 1'b1;
              rnd_next = 4'd4;
            end
            default: s_next = s;
          endcase
        end
      end
      S_ADPAD: begin
        s_next[0] = s[0] ^ {56'd0, ASC_PAD};
        rnd_next = 4'd4;
      end
      S_MSGPAD: s_next = s;
      S_FIN: begin
        if (pend) s_next[0] = s[0] ^ {56'd0, ASC_PAD};
        s_next[1] = s[1] ^ key_low;
        s_next[2] = s[2] ^ key_high;
        rnd_next = 4'd0;
        if (pend) s_next[1] = s[1] ^ key_low;
      end
      S_OUT: begin
        s_next[3] = s[3] ^ key_low;
        s_next[4] = s[4] ^ key_high;
      end
      S_INIT_KEY: s_next = s;
      default: begin
        s_next = round_fn(s, rnd);
        rnd_next = rnd + 4'd1;
      end
    endcase
  end

  // full last blocks carry a pending pad step
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      pend <= 1'b0;
      s <= '0;
      rnd <= 4'd0;
      empty <= 1'b1;
      last <= 1'b0;
    end else begin
      st <= st_next;
      s <= s_next;
      rnd <= rnd_next;
      if (take) pend <= cmd.fin && cmd.count == 4'd8;
      else if (st == S_FIN || st == S_ADPAD) pend <= 1'b0;
      if (take && cmd.op == OP_MSG) begin
        empty <= !(!cmd.fin);
        last <= cmd.fin;
      end else if (st == S_OUT) begin
        empty <= 1'b0;
      end else if (pop && !empty) begin
        empty <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      data_out <= o_next;
      out_count <= cmd.fin ? cmd.count : 4'd8;
      tag_low <= 64'd0;
      tag_high <= 64'd0;
    end else if (st == S_OUT) begin
      tag_low <= s[3] ^ key_low;
      tag_high <= s[4] ^ key_high;
    end
  end

  assert property (@(posedge clk) disable iff (rst) take |-> st == S_IDLE)
    else $error("command taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (take && cmd.op == OP_MSG) |-> empty)
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (rst)
    (st == S_FINPERM && rnd_done) |=> st == S_OUT)
    else $error("finalization lost");

endmodule

// ----- sv/ascon_aead_64bit_rate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascon_aead_64bit_rate
// Ascon AEAD with a 64-bit rate: front classifier, command queue, core.
// ----------------------------------------------------------------------------
// Blocks go through the one-round-a-cycle permutation unit in the core; a
// new item is taken only when the core is idle and, for message blocks,
// only when the result output is empty.
// Message results appear the cycle after the core takes the item; a final
// result appears after finalization.
// Synchronous reset clears state, phase, configuration registers and queues.
module ascon_aead_64bit_rate import asc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [63:0] data_in,
  input  logic [3:0]  byte_count,
  input  logic        is_last,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] data_out,
  output logic [3:0]  out_count,
  output logic [63:0] tag_low,
  output logic [63:0] tag_high,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [2:0] R_KEY_LOW = 3'd0;
  localparam logic [2:0] R_KEY_HIGH = 3'd1;
  localparam logic [2:0] R_NONCE_LOW = 3'd2;
  localparam logic [2:0] R_NONCE_HIGH = 3'd3;
  localparam logic [2:0] R_DECRYPT = 3'd4;

  logic [63:0] key_low, key_high, nonce_low, nonce_high;
  logic        decrypt_mode;
  logic        cmd_valid, q_full, q_empty, q_rd;
  cmd_t        cmd_w, cmd_r;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      nonce_low <= '0;
      nonce_high <= '0;
      decrypt_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        R_KEY_LOW: key_low <= pwdata;
        R_KEY_HIGH: key_high <= pwdata;
        R_NONCE_LOW: nonce_low <= pwdata;
        R_NONCE_HIGH: nonce_high <= pwdata;
        R_DECRYPT: decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      R_KEY_LOW: prdata = key_low;
      R_KEY_HIGH: prdata = key_high;
      R_NONCE_LOW: prdata = nonce_low;
      R_NONCE_HIGH: prdata = nonce_high;
      R_DECRYPT: prdata = {63'd0, decrypt_mode};
      default: prdata = '0;
    endcase
  end

  asc_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func),
    .data_in(data_in), .byte_count(byte_count), .is_last(is_last),
    .cmd_valid(cmd_valid), .cmd(cmd_w), .cmd_full(q_full)
  );

  asc_cmdq u_q (
    .clk(clk), .rst(rst), .wr(cmd_valid), .wdata(cmd_w), .full(q_full),
    .rd(q_rd), .rdata(cmd_r), .empty(q_empty)
  );

  asc_core u_core (
    .clk(clk), .rst(rst), .cmd_empty(q_empty), .cmd(cmd_r), .cmd_rd(q_rd),
    .key_low(key_low), .key_high(key_high), .nonce_low(nonce_low),
    .nonce_high(nonce_high), .decrypt_mode(decrypt_mode), .empty(empty),
    .pop(pop), .data_out(data_out), .out_count(out_count), .tag_low(tag_low),
    .tag_high(tag_high), .last(last)
  );

endmodule
